@@ rtl/sast_pkg.sv @@
// Shared constants and types for the segment versus box slab test.
// No dependencies; every module of the block imports this package.
package sast_pkg;

   localparam int COORD_W         = 32;
   localparam int DIFF_W          = COORD_W + 1;
   localparam int NUM_AXES        = 3;
   localparam int TIME_FRAC_DEF   = 16;
   localparam int REQ_DATA_W      = 4 * NUM_AXES * COORD_W;

   typedef struct packed {
      logic par;
      logic par_miss;
   } lane_flags_type;

endpackage

@@ rtl/segment_aabb_slab_test.sv @@
// Throughput: one word per cycle unless the result is stalled.
// Each axis lane runs two bit-per-stage dividers.
// A stalled result holds the whole pipeline; req_tready follows the output register.
// Reset is synchronous and clears the valid bits only; data registers are not reset.
// Depends on sast_pkg and sast_lane.
module segment_aabb_slab_test
   import sast_pkg::*;
#(
   parameter int TIME_FRAC_BITS = TIME_FRAC_DEF,
   parameter int RSP_DATA_W     = ((TIME_FRAC_BITS + 2 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit, hit_time, zero padding
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int LAT = TIME_FRAC_BITS + 6;
   localparam int TW  = TIME_FRAC_BITS + 3;
   localparam int HW  = TIME_FRAC_BITS + 1;
   localparam logic signed [TW-1:0] T_ONE = TW'(1 << TIME_FRAC_BITS);

   logic                 adv;
   logic [LAT-1:0]       vld_ff;
   logic                 rsp_valid_ff;
   logic                 hit_ff;
   logic [HW-1:0]        hit_time_ff;

   logic signed [TW-1:0] near_w [NUM_AXES];
   logic signed [TW-1:0] far_w  [NUM_AXES];
   lane_flags_type       fl_w   [NUM_AXES];

   logic signed [TW-1:0] entry, exit_t;
   logic                 miss;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      sast_lane #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_lane (
         .clock   (clock),
         .en      (adv),
         .start_c (req_tdata[a*COORD_W +: COORD_W]),
         .end_c   (req_tdata[(NUM_AXES + a)*COORD_W +: COORD_W]),
         .lo_c    (req_tdata[(2*NUM_AXES + a)*COORD_W +: COORD_W]),
         .hi_c    (req_tdata[(3*NUM_AXES + a)*COORD_W +: COORD_W]),
         .t_near  (near_w[a]),
         .t_far   (far_w[a]),
         .flags   (fl_w[a])
      );
   end

   always_comb begin
      entry  = '0;
      exit_t = T_ONE;
      miss   = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         if (fl_w[a].par) begin
            miss = miss | fl_w[a].par_miss;
         end else begin
            if (near_w[a] > entry) begin
               entry = near_w[a];
            end
            if (far_w[a] < exit_t) begin
               exit_t = far_w[a];
            end
         end
      end
      miss = miss | (entry > exit_t);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LAT-2:0], req_tvalid};
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff      <= !miss;
         hit_time_ff <= miss ? '0 : entry[HW-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({hit_time_ff, hit_ff});

endmodule

@@ rtl/sast_div.sv @@
// Pipelined saturating signed divider, one quotient bit per stage.
// Depends on sast_pkg.
module sast_div
   import sast_pkg::*;
#(
   parameter int TIME_FRAC_BITS = TIME_FRAC_DEF
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [DIFF_W-1:0]        num,
   input  logic signed [DIFF_W-1:0]        den,
   output logic signed [TIME_FRAC_BITS+2:0] ratio
);

   localparam int QW = TIME_FRAC_BITS + 2;
   localparam int RW = DIFF_W + 2;
   localparam logic [QW-1:0] SAT = QW'((1 << TIME_FRAC_BITS) + 1);

   logic [RW-1:0]     r_ff   [QW+1];
   logic [DIFF_W-1:0] ud_ff  [QW+1];
   logic [QW-1:0]     q_ff   [QW+1];
   logic              neg_ff [QW+1];
   logic              ovf_ff [QW+1];
   logic signed [QW:0] ratio_ff;

   logic [DIFF_W-1:0] un_in;
   logic [DIFF_W-1:0] ud_in;
   logic [QW-1:0]     qsat;

   always_comb begin
      un_in = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
      ud_in = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= RW'(un_in);
         ud_ff[0]  <= ud_in;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[DIFF_W-1] ^ den[DIFF_W-1];
         ovf_ff[0] <= {2'b00, un_in} >= {ud_in, 2'b00};
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [RW-1:0] dv;
      logic          ge;
      logic [RW-1:0] diff;
      always_comb begin
         dv   = (k == 0) ? {1'b0, ud_ff[k], 1'b0} : {2'b00, ud_ff[k]};
         ge   = r_ff[k] >= dv;
         diff = ge ? (r_ff[k] - dv) : r_ff[k];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1]   <= (k == 0) ? diff : {diff[RW-2:0], 1'b0};
            ud_ff[k+1]  <= ud_ff[k];
            q_ff[k+1]   <= {q_ff[k][QW-2:0], ge};
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   always_comb begin
      qsat = (ovf_ff[QW] || q_ff[QW] > SAT) ? SAT : q_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ratio_ff <= neg_ff[QW] ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
      end
   end

   assign ratio = ratio_ff;

endmodule

@@ rtl/sast_lane.sv @@
// One axis lane: slab differences, two dividers and ordering of the pair.
// Depends on sast_pkg and sast_div.
module sast_lane
   import sast_pkg::*;
#(
   parameter int TIME_FRAC_BITS = TIME_FRAC_DEF
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [COORD_W-1:0]        start_c,
   input  logic signed [COORD_W-1:0]        end_c,
   input  logic signed [COORD_W-1:0]        lo_c,
   input  logic signed [COORD_W-1:0]        hi_c,
   output logic signed [TIME_FRAC_BITS+2:0] t_near,
   output logic signed [TIME_FRAC_BITS+2:0] t_far,
   output lane_flags_type                   flags
);

   localparam int DLY = TIME_FRAC_BITS + 4;
   localparam int TW  = TIME_FRAC_BITS + 3;

   logic signed [DIFF_W-1:0] num_lo_ff, num_hi_ff, den_ff;
   lane_flags_type           fl_ff [DLY+1];
   logic signed [TW-1:0]     ra, rb;
   logic signed [TW-1:0]     near_ff, far_ff;
   lane_flags_type           flags_ff;

   logic signed [DIFF_W-1:0] s_w, e_w, l_w, h_w;

   always_comb begin
      s_w = {start_c[COORD_W-1], start_c};
      e_w = {end_c[COORD_W-1], end_c};
      l_w = {lo_c[COORD_W-1], lo_c};
      h_w = {hi_c[COORD_W-1], hi_c};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_lo_ff         <= l_w - s_w;
         num_hi_ff         <= h_w - s_w;
         den_ff            <= e_w - s_w;
         fl_ff[0].par      <= (e_w == s_w);
         fl_ff[0].par_miss <= (e_w == s_w) && ((s_w < l_w) || (s_w > h_w));
      end
   end

   sast_div #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_lo (
      .clock (clock),
      .en    (en),
      .num   (num_lo_ff),
      .den   (den_ff),
      .ratio (ra)
   );

   sast_div #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_hi (
      .clock (clock),
      .en    (en),
      .num   (num_hi_ff),
      .den   (den_ff),
      .ratio (rb)
   );

   for (genvar k = 0; k < DLY; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (en) begin
            fl_ff[k+1] <= fl_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         near_ff  <= (ra > rb) ? rb : ra;
         far_ff   <= (ra > rb) ? ra : rb;
         flags_ff <= fl_ff[DLY];
      end
   end

   assign t_near = near_ff;
   assign t_far  = far_ff;
   assign flags  = flags_ff;

endmodule

@@ rtl/sast_checker.sv @@
// Port-level checks for the segment versus box slab test.
// Depends on sast_pkg; bound to segment_aabb_slab_test at the end of this file.
module sast_checker
   import sast_pkg::*;
#(
   parameter int TIME_FRAC_BITS = TIME_FRAC_DEF,
   parameter int RSP_DATA_W     = ((TIME_FRAC_BITS + 2 + 7) / 8) * 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int HW = TIME_FRAC_BITS + 1;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("Result word dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("Result word changed while stalled.");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[HW:1] == '0)
      else $error("Miss carries a nonzero hit time.");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[HW:1] <= HW'(1 << TIME_FRAC_BITS))
      else $error("Hit time above one.");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("Input taken while the result stage is stalled.");

endmodule

bind segment_aabb_slab_test sast_checker #(
   .TIME_FRAC_BITS (TIME_FRAC_BITS),
   .RSP_DATA_W     (RSP_DATA_W)
) u_sast_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/sv/tb.sv @@
// Self-checking testbench for segment_aabb_slab_test: directed table plus random segment/box words.
// Expected results come from a local slab-method predictor. Depends on sast_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
   import sast_pkg::*;

   localparam int TFB      = TIME_FRAC_DEF;
   localparam int RSP_W    = ((TFB + 2 + 7) / 8) * 8;
   localparam int LATENCY  = TFB + 7;
   localparam int WATCHDOG = 20000;
   localparam longint T_ONE = 64'sd1 << TFB;

   typedef struct packed {
      logic [TFB:0] hit_time;
      logic         hit;
   } hit_word_type;

   typedef struct {
      logic [REQ_DATA_W-1:0] data;
      logic                  check_row;
      hit_word_type          row_result;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;

   hit_word_type expected_hits[$];
   int           mismatches = 0;
   int           idle_cycles = 0;
   bit           hold_rsp = 1'b0;
   bit           stim_done = 1'b0;
   stim_row_type rows[$];

   segment_aabb_slab_test uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic longint slab_quotient(longint num, longint den);
      longint un;
      longint ud;
      longint uq;
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      uq = (un << TFB) / ud;
      if (uq > T_ONE + 1) uq = T_ONE + 1;
      return ((num < 0) != (den < 0)) ? -uq : uq;
   endfunction

   function automatic hit_word_type predict_hit(logic [REQ_DATA_W-1:0] d);
      longint entry_t;
      longint exit_t;
      longint s, e, lo, hi, a, b, t;
      bit     miss;
      hit_word_type r;
      entry_t = 0;
      exit_t  = T_ONE;
      miss    = 1'b0;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         s  = longint'($signed(d[ax*COORD_W +: COORD_W]));
         e  = longint'($signed(d[(3+ax)*COORD_W +: COORD_W]));
         lo = longint'($signed(d[(6+ax)*COORD_W +: COORD_W]));
         hi = longint'($signed(d[(9+ax)*COORD_W +: COORD_W]));
         if (e == s) begin
            if (s < lo || s > hi) miss = 1'b1;
         end else begin
            a = slab_quotient(lo - s, e - s);
            b = slab_quotient(hi - s, e - s);
            if (a > b) begin
               t = a;
               a = b;
               b = t;
            end
            if (a > entry_t) entry_t = a;
            if (b < exit_t) exit_t = b;
         end
      end
      if (entry_t > exit_t) miss = 1'b1;
      r.hit      = !miss;
      r.hit_time = miss ? '0 : entry_t[TFB:0];
      return r;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_test(int sx, int sy, int sz, int ex, int ey,
         int ez, int nx, int ny, int nz, int mx, int my, int mz);
      return {mz, my, mx, nz, ny, nx, ez, ey, ex, sz, sy, sx};
   endfunction

   function automatic int rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 2000) - 1000;
         2: return ($urandom_range(0, 40) - 20) <<< 16;
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                : 32'h8000_0000 + $urandom_range(0, 3);
      endcase
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_test();
      int c[12];
      int mode;
      int lo_v, hi_v;
      mode = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 2) : $urandom_range(0, 3);
      for (int i = 0; i < 12; i++) c[i] = rand_coord(mode);
      for (int ax = 0; ax < 3; ax++) begin
         if ($urandom_range(0, 5) == 0) c[3+ax] = c[ax];
         if ($urandom_range(0, 4) != 0 && c[6+ax] > c[9+ax]) begin
            lo_v = c[9+ax];
            hi_v = c[6+ax];
            c[6+ax] = lo_v;
            c[9+ax] = hi_v;
         end
      end
      return pack_test(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]);
   endfunction

   task automatic add_row(logic [REQ_DATA_W-1:0] d, logic chk, logic h, int ht);
      stim_row_type r;
      r.data = d;
      r.check_row = chk;
      r.row_result.hit = h;
      r.row_result.hit_time = (TFB+1)'(ht);
      rows.insert(rows.size(), r);
   endtask

   task automatic send_word(logic [REQ_DATA_W-1:0] d);
      int gap;
      gap = ($urandom_range(0, 9) < 7) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      expected_hits.insert(expected_hits.size(), predict_hit(d));
   endtask

   localparam int P1 = 32'h0001_0000;
   localparam int MX = 32'h7FFF_FFFF;
   localparam int MN = 32'h8000_0000;

   initial begin
      // Directed rows: axis segments, parallel in/out, touching edges, inverted box, extremes.
      add_row(pack_test(0, 0, 0, 4*P1, 0, 0, P1, -P1, -P1, 2*P1, P1, P1), 1, 1, 16384);
      add_row(pack_test(0, 0, 0, 4*P1, 0, 0, P1, P1, -P1, 2*P1, 2*P1, P1), 1, 0, 0);
      add_row(pack_test(0, 0, 0, 0, 0, 0, -P1, -P1, -P1, P1, P1, P1), 1, 1, 0);
      add_row(pack_test(0, 0, 0, P1, 0, 0, P1, -P1, -P1, 2*P1, P1, P1), 1, 1, 65536);
      add_row(pack_test(0, 0, 0, P1, 0, 0, 2*P1, -P1, -P1, 3*P1, P1, P1), 1, 0, 0);
      add_row(pack_test(0, 0, 0, 0, P1, 0, P1, -P1, -P1, -P1, P1, P1), 1, 0, 0);
      add_row(pack_test(4*P1, 0, 0, 0, 0, 0, P1, -P1, -P1, 2*P1, P1, P1), 1, 1, 32768);
      add_row(pack_test(MN, MN, MN, MX, MX, MX, MN, MN, MN, MX, MX, MX), 1, 1, 0);
      add_row(pack_test(MX, MX, MX, MN, MN, MN, 0, 0, 0, 0, 0, 0), 0, 0, 0);
      add_row(pack_test(MN, 0, 0, MX, 0, 0, MX, MN, MN, MX, MX, MX), 0, 0, 0);
      add_row(pack_test(0, 0, 0, 3*P1, 3*P1, 3*P1, P1, P1, P1, MX, MX, MX), 0, 0, 0);
      add_row(pack_test(MX, MN, MX, MX, MN, MX, MN, MN, MN, MX, MX, MX), 1, 1, 0);
      add_row(pack_test(-1, -1, -1, 1, 1, 1, 0, 0, 0, 0, 0, 0), 0, 0, 0);
      add_row(pack_test(0, 0, 0, 2*P1, 2*P1, 0, P1, 3*P1, -P1, 2*P1, 4*P1, P1), 1, 0, 0);
      add_row(pack_test(0, 0, 0, 3, 7, 11, 1, 2, 3, 5, 9, 13), 0, 0, 0);
      add_row(pack_test(MN, MN, MN, MN, MN, MN, MX, MX, MX, MN, MN, MN), 1, 0, 0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         send_word(rows[i].data);
         if (rows[i].check_row && expected_hits[$] !== rows[i].row_result) begin
            mismatches++;
            if (mismatches <= 10)
               $display("table row %0d: expected %p, predictor %p", i, rows[i].row_result,
                        expected_hits[$]);
         end
      end
      for (int n = 0; n < 1000; n++) begin
         send_word(random_test());
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (!reset);
      repeat (300) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (200) @(posedge clock);
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
         rsp_tready <= 1'b0;
      end else if (!rsp_tready && $urandom_range(0, 40) == 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      hit_word_type got;
      hit_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[TFB+1:0];
         if (expected_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_tdata);
         end else begin
            want = expected_hits.pop_front();
            if (got.hit !== want.hit || got.hit_time !== want.hit_time) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: hit %b/%b hit_time %0d/%0d (expected/actual)",
                           want.hit, got.hit, want.hit_time, got.hit_time);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (stim_done);
      while (expected_hits.size() != 0 && idle_cycles < WATCHDOG) @(posedge clock);
      if (idle_cycles >= WATCHDOG) begin
         $display("FAIL segment_aabb_slab_test");
      end else begin
         repeat (LATENCY + 10) @(posedge clock);
         if (mismatches == 0) begin
            $display("PASS segment_aabb_slab_test");
         end else begin
            $display("FAIL segment_aabb_slab_test");
         end
      end
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG);
      if (!stim_done) begin
         $display("FAIL segment_aabb_slab_test");
         $finish;
      end
   end

endmodule
